// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SLT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/slt_pkg.sv -----
// Package for the sorted list table: request and status codes, widths,
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package slt_pkg;

    // Default sizes of the table.
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed port widths.
    localparam int TYPE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;
    localparam int WIDE_W  = 64;

    // The read path selects inside groups of eight cells first.
    localparam int GRP_LO_W = 3;
    localparam int GRP_SIZE = 8;

    // Request codes.
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_GET    = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_TEST   = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Selection of what a response carries.
    localparam logic [2:0] RESP_INSERT = 3'd0;
    localparam logic [2:0] RESP_FULL   = 3'd1;
    localparam logic [2:0] RESP_REMOVE = 3'd2;
    localparam logic [2:0] RESP_GET    = 3'd3;
    localparam logic [2:0] RESP_RANGE  = 3'd4;
    localparam logic [2:0] RESP_TEST   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;       // capture the request fields
        logic       do_insert;  // shift cells right and place the value
        logic       do_remove;  // shift out the first equal entry
        logic       load_read;  // first stage of the indexed read
        logic       respond;    // register a result
        logic [2:0] sel;        // what the result carries
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [TYPE_W-1:0] op;
        logic              full;
        logic              range_err;
        logic              any_eq;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/slt_dpath.sv -----
// Datapath of the sorted list table: a row of shifting cells with a compare in
// each cell, a two-stage indexed read and the result registers. Uses slt_pkg.
`default_nettype none

module slt_dpath #(
    parameter int CAPACITY   = slt_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire slt_pkg::t_cmd                i_cmd,
    output slt_pkg::t_sts                     o_sts,
    input  wire logic [slt_pkg::TYPE_W-1:0]   i_req_type,
    input  wire logic [slt_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [slt_pkg::POS_W-1:0]    i_position,
    output logic      [slt_pkg::VALUE_W-1:0]  o_read_value,
    output logic                              o_hit,
    output logic      [slt_pkg::COUNT_W-1:0]  o_count,
    output logic      [slt_pkg::STAT_W-1:0]   o_status
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int GROUPS  = (CAPACITY + slt_pkg::GRP_SIZE - 1) / slt_pkg::GRP_SIZE;
    localparam int GSEL_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    // Request held for the whole transaction.
    logic [slt_pkg::TYPE_W-1:0] r_op;
    logic [DATA_WIDTH-1:0]      r_val;
    logic [slt_pkg::POS_W-1:0]  r_pos;
    logic [slt_pkg::WIDE_W-1:0] value_wide;

    // Table state.
    logic [DATA_WIDTH-1:0] r_entries [CAPACITY];
    logic [CNT_W-1:0]      r_count;
    logic                  r_hit_acc;

    // Per-cell flags.
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_ge;
    logic [CAPACITY-1:0] cell_move;

    // Read path.
    logic [15:0]             pos_ext;
    logic [GSEL_W-1:0]       grp_hi;
    logic [DATA_WIDTH-1:0]   cand [GROUPS][slt_pkg::GRP_SIZE];
    logic [DATA_WIDTH-1:0]   r_grp [GROUPS];
    logic [DATA_WIDTH-1:0]   grp_out;
    logic [slt_pkg::WIDE_W-1:0] read_wide;

    // Result count before truncation to the port.
    logic [CNT_W-1:0] count_src;
    logic [15:0]      count_wide;

    assign value_wide = slt_pkg::WIDE_W'(i_value);

    // Capture the request at the start of a transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req_type;
            r_val <= value_wide[DATA_WIDTH-1:0];
            r_pos <= i_position;
        end
    end

    // Count and removal flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_hit_acc <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_hit_acc <= 1'b0;
            end else if (i_cmd.do_remove) begin
                r_hit_acc <= 1'b1;
            end
            if (i_cmd.do_insert) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.do_remove) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // The cell row: each cell compares its entry with the request value and
    // takes its neighbour's entry when the row shifts.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign cell_valid[i] = (CNT_W'(i) < r_count);
        assign cell_eq[i]    = cell_valid[i] && (r_entries[i] == r_val);
        assign cell_ge[i]    = cell_valid[i] && (r_entries[i] >= r_val);
        assign cell_move[i]  = (cell_valid[i] && (r_entries[i] > r_val))
                               || (r_count == CNT_W'(i));

        if (i == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_cmd.do_insert && cell_move[i]) begin
                    r_entries[i] <= r_val;
                end else if (i_cmd.do_remove && cell_ge[i]) begin
                    r_entries[i] <= r_entries[i+1];
                end
            end
        end else if (i == CAPACITY - 1) begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_cmd.do_insert && cell_move[i]) begin
                    r_entries[i] <= cell_move[i-1] ? r_entries[i-1] : r_val;
                end
            end
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_cmd.do_insert && cell_move[i]) begin
                    r_entries[i] <= cell_move[i-1] ? r_entries[i-1] : r_val;
                end else if (i_cmd.do_remove && cell_ge[i]) begin
                    r_entries[i] <= r_entries[i+1];
                end
            end
        end
    end

    // Status to the controller.
    assign pos_ext         = 16'(r_pos);
    assign o_sts.op        = r_op;
    assign o_sts.full      = (r_count == CNT_W'(CAPACITY));
    assign o_sts.range_err = (pos_ext >= 16'(r_count));
    assign o_sts.any_eq    = |cell_eq;

    // First read stage: one entry out of each group of eight, registered.
    for (genvar g = 0; g < GROUPS; g++) begin : g_grp
        for (genvar k = 0; k < slt_pkg::GRP_SIZE; k++) begin : g_k
            if (g * slt_pkg::GRP_SIZE + k < CAPACITY) begin : g_on
                assign cand[g][k] = r_entries[g * slt_pkg::GRP_SIZE + k];
            end else begin : g_off
                assign cand[g][k] = '0;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_cmd.load_read) begin
                r_grp[g] <= cand[g][pos_ext[slt_pkg::GRP_LO_W-1:0]];
            end
        end
    end

    // Second read stage: pick the group.
    assign grp_hi    = pos_ext[GSEL_W+slt_pkg::GRP_LO_W-1:slt_pkg::GRP_LO_W];
    assign grp_out   = r_grp[grp_hi];
    assign read_wide = slt_pkg::WIDE_W'(grp_out);

    // Count reported with this result.
    assign count_src  = (i_cmd.sel == slt_pkg::RESP_INSERT) ? r_count + CNT_W'(1) : r_count;
    assign count_wide = 16'(count_src);

    // Result registers, loaded once per transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            o_count      <= count_wide[slt_pkg::COUNT_W-1:0];
            o_read_value <= '0;
            o_hit        <= 1'b0;
            o_status     <= slt_pkg::ST_OK;
            case (i_cmd.sel)
                slt_pkg::RESP_FULL: begin
                    o_status <= slt_pkg::ST_FULL;
                end
                slt_pkg::RESP_REMOVE: begin
                    o_hit <= r_hit_acc;
                end
                slt_pkg::RESP_GET: begin
                    o_read_value <= read_wide[slt_pkg::VALUE_W-1:0];
                end
                slt_pkg::RESP_RANGE: begin
                    o_status <= slt_pkg::ST_RANGE;
                end
                slt_pkg::RESP_TEST: begin
                    o_hit <= |cell_eq;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/slt_ctrl.sv -----
// Controller of the sorted list table: sequences each request and issues the
// datapath commands. Uses slt_pkg.
`default_nettype none

module slt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               o_done,
    input  wire slt_pkg::t_sts i_sts,
    output slt_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_done;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = slt_pkg::RESP_TEST;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    slt_pkg::REQ_INSERT: begin
                        o_cmd.respond   = 1'b1;
                        o_cmd.do_insert = !i_sts.full;
                        o_cmd.sel       = i_sts.full ? slt_pkg::RESP_FULL
                                                     : slt_pkg::RESP_INSERT;
                        n_state         = S_IDLE;
                    end
                    slt_pkg::REQ_REMOVE: begin
                        // One matching entry leaves the row per cycle.
                        if (i_sts.any_eq) begin
                            o_cmd.do_remove = 1'b1;
                        end else begin
                            o_cmd.respond = 1'b1;
                            o_cmd.sel     = slt_pkg::RESP_REMOVE;
                            n_state       = S_IDLE;
                        end
                    end
                    slt_pkg::REQ_GET: begin
                        if (i_sts.range_err) begin
                            o_cmd.respond = 1'b1;
                            o_cmd.sel     = slt_pkg::RESP_RANGE;
                            n_state       = S_IDLE;
                        end else begin
                            o_cmd.load_read = 1'b1;
                            n_state         = S_READ;
                        end
                    end
                    default: begin
                        o_cmd.respond = 1'b1;
                        o_cmd.sel     = slt_pkg::RESP_TEST;
                        n_state       = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.respond = 1'b1;
                o_cmd.sel     = slt_pkg::RESP_GET;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.respond;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- sv/sorted_list_table.sv -----
// Sorted list table: holds up to CAPACITY unsigned values in ascending order and
// serves insert, remove-all-equal, get-at-index and membership test requests.
// A request is taken when start is high and busy is low. Its one result appears
// on the result ports for a single cycle with o_done high; the receiver cannot
// stall it, so it must take the result in that cycle. Insert, test and an
// out-of-range get are answered from the controller's execute state; an in-range
// get passes through the two registered stages of the indexed read; a remove
// holds the execute state while the cell row shifts out one matching entry per
// cycle and answers once no equal entry is left. A new request may be accepted
// at the edge that ends the strobe cycle.
// Depends on slt_pkg, slt_ctrl and slt_dpath.
`default_nettype none

module sorted_list_table #(
    parameter int CAPACITY   = slt_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [slt_pkg::TYPE_W-1:0]   i_req_type,
    input  wire logic [slt_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [slt_pkg::POS_W-1:0]    i_position,
    output logic                              o_done,
    output logic      [slt_pkg::VALUE_W-1:0]  o_read_value,
    output logic                              o_hit,
    output logic      [slt_pkg::COUNT_W-1:0]  o_count,
    output logic      [slt_pkg::STAT_W-1:0]   o_status
);

    slt_pkg::t_cmd cmd;
    slt_pkg::t_sts sts;

    // Request sequencing.
    slt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Cell row, read path and result registers.
    slt_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_read_value (o_read_value),
        .o_hit        (o_hit),
        .o_count      (o_count),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

// ----- sv/slt_checker.sv -----
// Port-level checker for the sorted list table, bound to the top level.
// Depends on slt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module slt_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         o_done,
    input wire logic [slt_pkg::VALUE_W-1:0]  o_read_value,
    input wire logic                         o_hit,
    input wire logic [slt_pkg::STAT_W-1:0]   o_status
);

    // An accepted transaction keeps the block busy in the following cycle.
    `SLT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after accept")

    // Results never come in two consecutive cycles.
    `SLT_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "two result strobes in a row")

    // Only defined status codes are reported.
    `SLT_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_done, o_status == slt_pkg::ST_OK || o_status == slt_pkg::ST_FULL || o_status == slt_pkg::ST_RANGE, "undefined status code")

    // A failed request carries neither data nor a hit.
    `SLT_ASSERT_SAME(a_fail_empty, i_clk, i_rst_n, o_done && o_status != slt_pkg::ST_OK, o_read_value == '0 && !o_hit, "failed request carries data")

endmodule

bind sorted_list_table slt_checker u_slt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_read_value (o_read_value),
    .o_hit        (o_hit),
    .o_status     (o_status)
);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the sorted list table: directed and random request
// transactions, checked field by field against an in-bench model of the ordered store.
// Depends on slt_pkg and the sorted_list_table RTL; reads no files.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = slt_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 10;

    // One request transaction and the one result it causes.
    typedef struct packed {
        logic [slt_pkg::TYPE_W-1:0]  kind;
        logic [slt_pkg::VALUE_W-1:0] value;
        logic [slt_pkg::POS_W-1:0]   pos;
    } table_req_t;

    typedef struct packed {
        logic [slt_pkg::VALUE_W-1:0] read_value;
        logic                        hit;
        logic [slt_pkg::COUNT_W-1:0] count;
        logic [slt_pkg::STAT_W-1:0]  status;
    } table_resp_t;

    // Ports of the block; every input starts at a known value.
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [slt_pkg::TYPE_W-1:0]  i_req_type = slt_pkg::REQ_TEST;
    logic [slt_pkg::VALUE_W-1:0] i_value = '0;
    logic [slt_pkg::POS_W-1:0]   i_position = '0;
    logic                        o_done;
    logic [slt_pkg::VALUE_W-1:0] o_read_value;
    logic                        o_hit;
    logic [slt_pkg::COUNT_W-1:0] o_count;
    logic [slt_pkg::STAT_W-1:0]  o_status;

    // Stimulus, expectations and the model of the ordered store.
    table_req_t                  pending_requests[$];
    table_resp_t                 expected_responses[$];
    logic [slt_pkg::VALUE_W-1:0] model_entries[TABLE_DEPTH];
    int                          model_count = 0;

    table_req_t  next_req;
    table_resp_t predicted;
    table_resp_t oldest;
    int          total_requests;
    int          accepted = 0;
    int          idle_pct;
    int          error_count = 0;
    int          stall_cycles = 0;
    int          checked_responses = 0;
    int          kind_seen[4] = '{0, 0, 0, 0};
    int          full_rejects = 0;
    int          range_rejects = 0;
    int          remove_hits = 0;
    int          peak_count = 0;

    sorted_list_table dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_done       (o_done),
        .o_read_value (o_read_value),
        .o_hit        (o_hit),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    // Clock with a 10 ns period.
    always #5 i_clk = ~i_clk;

    // Applies one request to the model and returns the result it should give.
    function automatic table_resp_t predict_response(table_req_t req);
        table_resp_t resp;
        int          at;
        int          keep;
        int          idx;
        resp = '0;
        resp.status = slt_pkg::ST_OK;
        case (req.kind)
            slt_pkg::REQ_INSERT: begin
                if (model_count >= TABLE_DEPTH) begin
                    resp.status = slt_pkg::ST_FULL;
                end else begin
                    // Equal values already held stay ahead of the new one.
                    at = 0;
                    while (at < model_count && model_entries[at] <= req.value) at++;
                    for (idx = model_count; idx > at; idx--)
                        model_entries[idx] = model_entries[idx - 1];
                    model_entries[at] = req.value;
                    model_count++;
                end
            end
            slt_pkg::REQ_REMOVE: begin
                keep = 0;
                for (idx = 0; idx < model_count; idx++) begin
                    if (model_entries[idx] == req.value) begin
                        resp.hit = 1'b1;
                    end else begin
                        model_entries[keep] = model_entries[idx];
                        keep++;
                    end
                end
                model_count = keep;
            end
            slt_pkg::REQ_GET: begin
                if (int'(req.pos) >= model_count) resp.status = slt_pkg::ST_RANGE;
                else resp.read_value = model_entries[req.pos];
            end
            default: begin
                for (idx = 0; idx < model_count; idx++)
                    if (model_entries[idx] == req.value) resp.hit = 1'b1;
            end
        endcase
        resp.count = slt_pkg::COUNT_W'(model_count);
        return resp;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(string field, logic [slt_pkg::VALUE_W-1:0] want,
                                   logic [slt_pkg::VALUE_W-1:0] got);
        $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h",
                 $time, field, want, got);
        error_count++;
    endtask

    task automatic queue_request(logic [slt_pkg::TYPE_W-1:0] kind,
                                 logic [slt_pkg::VALUE_W-1:0] value,
                                 logic [slt_pkg::POS_W-1:0] pos);
        pending_requests.push_back(table_req_t'{kind: kind, value: value, pos: pos});
    endtask

    // Values mostly come from a small pool so that hits and duplicates are common.
    function automatic logic [slt_pkg::VALUE_W-1:0] pick_value(
        logic [slt_pkg::VALUE_W-1:0] pool_base, int span);
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        if (r < 25) return $urandom;
        return pool_base + slt_pkg::VALUE_W'($urandom_range(span - 1));
    endfunction

    // Driver: records each accepted transaction and offers the next pending one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predicted = predict_response(table_req_t'{kind: i_req_type, value: i_value,
                                                          pos: i_position});
                expected_responses.push_back(predicted);
                accepted++;
                kind_seen[i_req_type]++;
                if (predicted.status == slt_pkg::ST_FULL) full_rejects++;
                if (predicted.status == slt_pkg::ST_RANGE) range_rejects++;
                if (i_req_type == slt_pkg::REQ_REMOVE && predicted.hit) remove_hits++;
                if (model_count > peak_count) peak_count = model_count;
            end
            if (!start || !busy) begin
                // The sender idles sometimes, then often, then not at all.
                if (accepted < total_requests / 3) idle_pct = 33;
                else if (accepted < 2 * total_requests / 3) idle_pct = 88;
                else idle_pct = 0;
                if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_req = pending_requests.pop_front();
                    start <= 1'b1;
                    i_req_type <= next_req.kind;
                    i_value <= next_req.value;
                    i_position <= next_req.pos;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_responses.size() == 0) begin
                $display("%0t ns: result transaction with no request outstanding", $time);
                error_count++;
            end else begin
                oldest = expected_responses.pop_front();
                checked_responses++;
                if (o_read_value !== oldest.read_value)
                    report_mismatch("read_value", oldest.read_value, o_read_value);
                if (o_hit !== oldest.hit)
                    report_mismatch("hit", slt_pkg::VALUE_W'(oldest.hit),
                                    slt_pkg::VALUE_W'(o_hit));
                if (o_count !== oldest.count)
                    report_mismatch("count", slt_pkg::VALUE_W'(oldest.count),
                                    slt_pkg::VALUE_W'(o_count));
                if (o_status !== oldest.status)
                    report_mismatch("status", slt_pkg::VALUE_W'(oldest.status),
                                    slt_pkg::VALUE_W'(o_status));
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles < STALL_LIMIT) begin
            stall_cycles <= stall_cycles + 1;
        end else begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_responses.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        int                          mode;
        int                          span;
        int                          episode_len;
        int                          r;
        int                          cut_insert;
        int                          cut_remove;
        int                          cut_get;
        logic [slt_pkg::VALUE_W-1:0] pool_base;
        logic [slt_pkg::TYPE_W-1:0]  kind;
        logic [slt_pkg::POS_W-1:0]   pos;

        // Directed: empty table, extremes of value, duplicates, range edges.
        queue_request(slt_pkg::REQ_GET,    '0,            6'd0);
        queue_request(slt_pkg::REQ_TEST,   '0,            6'd63);
        queue_request(slt_pkg::REQ_REMOVE, '0,            6'd21);
        queue_request(slt_pkg::REQ_INSERT, '1,            6'd42);
        queue_request(slt_pkg::REQ_INSERT, '0,            6'd0);
        queue_request(slt_pkg::REQ_INSERT, 32'd5,         6'd63);
        queue_request(slt_pkg::REQ_INSERT, 32'd5,         6'd1);
        queue_request(slt_pkg::REQ_INSERT, 32'h8000_0000, 6'd2);
        queue_request(slt_pkg::REQ_INSERT, 32'd5,         6'd3);
        queue_request(slt_pkg::REQ_GET,    '1,            6'd0);
        queue_request(slt_pkg::REQ_GET,    '0,            6'd4);
        queue_request(slt_pkg::REQ_GET,    '0,            6'd5);
        queue_request(slt_pkg::REQ_GET,    '0,            6'd6);
        queue_request(slt_pkg::REQ_GET,    '0,            6'd63);
        queue_request(slt_pkg::REQ_TEST,   32'd5,         6'd0);
        queue_request(slt_pkg::REQ_TEST,   32'd7,         6'd0);
        queue_request(slt_pkg::REQ_TEST,   '1,            6'd0);
        queue_request(slt_pkg::REQ_REMOVE, 32'd5,         6'd0);
        queue_request(slt_pkg::REQ_REMOVE, 32'd5,         6'd63);
        queue_request(slt_pkg::REQ_GET,    '0,            6'd1);
        queue_request(slt_pkg::REQ_REMOVE, '1,            6'd0);
        queue_request(slt_pkg::REQ_REMOVE, '0,            6'd0);
        queue_request(slt_pkg::REQ_REMOVE, 32'h8000_0000, 6'd0);

        // Random episodes: balanced traffic, filling past full, draining,
        // and heavy duplicates for long remove sweeps.
        while (pending_requests.size() < RANDOM_ITEMS + 23) begin
            mode = $urandom_range(3);
            episode_len = $urandom_range(40, 130);
            case ($urandom_range(2))
                0: pool_base = '0;
                1: pool_base = 32'hFFFF_FFF0;
                default: pool_base = $urandom;
            endcase
            span = 16;
            case (mode)
                0: begin cut_insert = 40; cut_remove = 55; cut_get = 80; end
                1: begin cut_insert = 80; cut_remove = 80; cut_get = 92; end
                2: begin cut_insert = 10; cut_remove = 65; cut_get = 85; end
                default: begin
                    cut_insert = 55; cut_remove = 62; cut_get = 82; span = 2;
                end
            endcase
            repeat (episode_len) begin
                r = $urandom_range(99);
                if (r < cut_insert) kind = slt_pkg::REQ_INSERT;
                else if (r < cut_remove) kind = slt_pkg::REQ_REMOVE;
                else if (r < cut_get) kind = slt_pkg::REQ_GET;
                else kind = slt_pkg::REQ_TEST;
                pos = ($urandom_range(1) != 0) ? slt_pkg::POS_W'($urandom_range(63))
                                               : slt_pkg::POS_W'($urandom_range(7));
                queue_request(kind, pick_value(pool_base, span), pos);
            end
        end
        total_requests = pending_requests.size();

        // Hold synchronous reset, then release it.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transaction to be taken and every result to arrive.
        @(negedge i_clk);
        while (pending_requests.size() != 0 || start || expected_responses.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_responses.size() != 0) begin
            $display("%0d expected results never arrived", expected_responses.size());
            error_count++;
        end

        $display("Ran %0d requests (insert %0d, remove %0d, get %0d, test %0d); %0d results checked.",
                 accepted, kind_seen[slt_pkg::REQ_INSERT], kind_seen[slt_pkg::REQ_REMOVE],
                 kind_seen[slt_pkg::REQ_GET], kind_seen[slt_pkg::REQ_TEST], checked_responses);
        $display("Inserts refused as full %0d, gets out of range %0d, removes that hit %0d, peak occupancy %0d of %0d.",
                 full_rejects, range_rejects, remove_hits, peak_count, TABLE_DEPTH);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
